### design/fic_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fletcher ISO checksum package
// Shared constants and the modulo-255 helpers of the checksum datapath.
// ----------------------------------------------------------------------------
package fic_pkg;

  localparam int unsigned DataWidth  = 8;
  localparam int unsigned CountWidth = 16;
  localparam int unsigned CheckWidth = 16;

  localparam logic [9:0] ModBase     = 10'd255;
  localparam logic [9:0] ModBaseTwo  = 10'd510;
  localparam logic [CountWidth-1:0] SkipBytes = CountWidth'(2);
  localparam logic [CountWidth-1:0] CountMax  = {CountWidth{1'b1}};

  // Reduce a value below 765 to the range 0..254.
  function automatic logic [DataWidth-1:0] mod255_small(input logic [9:0] val);
    logic [9:0] res;
    if (val >= ModBaseTwo) begin
      res = val - ModBaseTwo;
    end else if (val >= ModBase) begin
      res = val - ModBase;
    end else begin
      res = val;
    end
    return res[DataWidth-1:0];
  endfunction

  // 16-bit value modulo 255: 256 is 1 mod 255, so add the two bytes.
  function automatic logic [DataWidth-1:0] mod255_fold(input logic [15:0] val);
    logic [9:0] sum;
    sum = {2'b00, val[15:8]} + {2'b00, val[7:0]};
    return mod255_small(sum);
  endfunction

endpackage

### design/fletcher_iso_checksum.sv
`timescale 1ns / 1ps
// After the last byte, the result passes the five result registers to m_axis_tvalid.
// Throughput: one byte per cycle unless stalled; the sums update in one step per byte.
// The result path has five registers (capture, fold, 8x8 multiply, reduce, output).
// A result held by m_axis_tready low stalls the whole result path and the input.
// Reset clears the sums, the byte count, check_position and all pipeline valids.
// ----------------------------------------------------------------------------
// Fletcher ISO checksum
// Mod-255 Fletcher sums over a byte stream, first two bytes skipped; emits
// verify sums or computed check bytes at the end of each message.
// ----------------------------------------------------------------------------
module fletcher_iso_checksum
  import fic_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write: check_position
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CountWidth-1:0] cfg_data_i,
  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,  // [7:0] data_byte
  input  logic                  s_axis_tlast,  // last_byte
  // output stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [15:0]           m_axis_tdata   // [15:0] check_value
);

  logic [CountWidth-1:0] pos_q;
  logic [DataWidth-1:0]  a_q, a_d, b_q, b_d;
  logic [CountWidth-1:0] count_q, count_d;

  logic in_xfer, advance;

  // stage 1: final sums and offset term
  logic                  s1_valid_q, s1_verify_q;
  logic [DataWidth-1:0]  s1_a_q, s1_b_q;
  logic [CountWidth-1:0] s1_sop_q;
  // stage 2: sop modulo 255
  logic                  s2_valid_q, s2_verify_q;
  logic [DataWidth-1:0]  s2_a_q, s2_b_q, s2_sop_q;
  // stage 3: product
  logic                  s3_valid_q, s3_verify_q;
  logic [DataWidth-1:0]  s3_a_q, s3_b_q;
  logic [15:0]           s3_prod_q;
  // stage 4: check byte x
  logic                  s4_valid_q, s4_verify_q;
  logic [DataWidth-1:0]  s4_a_q, s4_b_q, s4_x_q;
  // output register
  logic                  out_valid_q, out_verify_q;
  logic [CheckWidth-1:0] out_data_q;

  logic [9:0]            a_sum, b_sum, x_sum, y_sum;
  logic [DataWidth-1:0]  a_acc, b_acc, x_red, x_val, y_val;
  logic [CountWidth-1:0] sop_val;

  assign cfg_ready     = 1'b1;
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = advance;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (cfg_valid && cfg_ready) begin
      pos_q <= cfg_data_i;
    end
  end

  // running sums
  always_comb begin
    a_sum = {2'b00, a_q} + {2'b00, s_axis_tdata};
    a_acc = mod255_small(a_sum);
    b_sum = {2'b00, b_q} + {2'b00, a_acc};
    b_acc = mod255_small(b_sum);
    if (count_q >= SkipBytes) begin
      a_d = a_acc;
      b_d = b_acc;
    end else begin
      a_d = a_q;
      b_d = b_q;
    end
    count_d = (count_q == CountMax) ? count_q : count_q + CountWidth'(1);
    sop_val = count_d - pos_q - CountWidth'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q     <= '0;
      b_q     <= '0;
      count_q <= '0;
    end else if (in_xfer) begin
      if (s_axis_tlast) begin
        a_q     <= '0;
        b_q     <= '0;
        count_q <= '0;
      end else begin
        a_q     <= a_d;
        b_q     <= b_d;
        count_q <= count_d;
      end
    end
  end

  // x = (sop*a - b) mod 255, zero maps to 255; y = 510 - x - a, folded once
  always_comb begin
    x_sum = {2'b00, s3_prod_q[15:8]} + {2'b00, s3_prod_q[7:0]}
          + (ModBase - {2'b00, s3_b_q});
    x_red = mod255_small(x_sum);
    x_val = (x_red == '0) ? ModBase[DataWidth-1:0] : x_red;
    y_sum = ModBaseTwo - {2'b00, s4_x_q} - {2'b00, s4_a_q};
    y_val = (y_sum > ModBase) ? 8'(y_sum - ModBase) : y_sum[DataWidth-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q  <= in_xfer && s_axis_tlast;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      s4_valid_q  <= s3_valid_q;
      out_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_verify_q  <= (pos_q == '0);
      s1_a_q       <= a_d;
      s1_b_q       <= b_d;
      s1_sop_q     <= sop_val;

      s2_verify_q  <= s1_verify_q;
      s2_a_q       <= s1_a_q;
      s2_b_q       <= s1_b_q;
      s2_sop_q     <= mod255_fold(s1_sop_q);

      s3_verify_q  <= s2_verify_q;
      s3_a_q       <= s2_a_q;
      s3_b_q       <= s2_b_q;
      s3_prod_q    <= {8'd0, s2_sop_q} * {8'd0, s2_a_q};

      s4_verify_q  <= s3_verify_q;
      s4_a_q       <= s3_a_q;
      s4_b_q       <= s3_b_q;
      s4_x_q       <= x_val;

      out_verify_q <= s4_verify_q;
      out_data_q   <= s4_verify_q ? {s4_a_q, s4_b_q} : {s4_x_q, y_val};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // sums stay reduced modulo 255
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_q != 8'd255) && (b_q != 8'd255))
    else $error("running sum left unreduced");

  // message state clears after the last transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && s_axis_tlast) |=> (a_q == '0 && b_q == '0 && count_q == '0))
    else $error("message state not cleared");

  // a held result stalls the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while pipeline stalled");

  // computed check bytes are never zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_verify_q) |-> (out_data_q[15:8] != '0 && out_data_q[7:0] != '0))
    else $error("check byte is zero");

endmodule
